// File: rtl/wbs_pkg.sv
// Shared types and constants of the weighted branch sampler.
// Used by the channel interfaces and the top level.
`default_nettype none

package wbs_pkg;

	// Default sizing of the block
	localparam int MAX_BRANCHES_DEF = 256;
	localparam int MAX_GAMMAS_DEF   = 8;
	localparam int RANDOM_BITS_DEF  = 24;

	// Field widths of the channel words
	localparam int REQ_TYPE_W = 2;
	localparam int BRANCH_W   = 8;
	localparam int SLOT_W     = 3;
	localparam int WEIGHT_W   = 16;
	localparam int GCOUNT_W   = 4;
	localparam int ENERGY_W   = 18;
	localparam int RANDOM_W   = 24;
	localparam int STATUS_W   = 3;
	localparam int NUM_BR_W   = 9;

	// Running weight total: 256 addressable branches of 16-bit weight
	localparam int TOTAL_W = 24;

	// Request codes
	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_BRANCH = 2'd0,
		REQ_ENERGY = 2'd1,
		REQ_SAMPLE = 2'd2
	} req_type_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_GAMMA    = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_NODATA   = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_WRITE    = 3'd4
	} status_t;

	// Controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WUPD,
		S_WALK,
		S_ERD,
		S_EOUT,
		S_RESULT
	} state_t;

endpackage

`default_nettype wire

// File: rtl/wbs_if.sv
// Valid/ready channel interfaces of the weighted branch sampler:
// request words, result words and the num_branches register write. Uses wbs_pkg.
`default_nettype none

interface wbs_req_if import wbs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [BRANCH_W-1:0]   branch_index;
	logic [SLOT_W-1:0]     gamma_slot;
	logic [WEIGHT_W-1:0]   weight;
	logic [GCOUNT_W-1:0]   gamma_count;
	logic [ENERGY_W-1:0]   energy_in;
	logic [RANDOM_W-1:0]   random_fraction;

	modport source (output valid, req_type, branch_index, gamma_slot, weight,
		gamma_count, energy_in, random_fraction, input ready);
	modport sink (input valid, req_type, branch_index, gamma_slot, weight,
		gamma_count, energy_in, random_fraction, output ready);
endinterface

interface wbs_rsp_if import wbs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ENERGY_W-1:0] energy_out;
	logic [BRANCH_W-1:0] chosen_branch;
	logic                last;

	modport source (output valid, status, energy_out, chosen_branch, last,
		input ready);
	modport sink (input valid, status, energy_out, chosen_branch, last,
		output ready);
endinterface

interface wbs_cfg_if import wbs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [NUM_BR_W-1:0] num_branches;

	modport source (output valid, num_branches, input ready);
	modport sink (input valid, num_branches, output ready);
endinterface

`default_nettype wire

// File: rtl/weighted_branch_sampler.sv
// Top level of the weighted branch sampler: controller, branch table RAM,
// gamma energy RAM and result register. Depends on wbs_pkg, wbs_if, wbs_ram.
//
// The block keeps a table of decay branches (weight and gamma count per branch,
// plus up to MAX_GAMMAS gamma energies each) and a running total of all weights.
// A weight/count write reads the old weight, writes back and loads the result;
// an energy write writes the energy RAM and loads the result. After a sample word
// is taken, the walk reads one branch per cycle from the branch RAM until the
// first hit or the last branch. Each gamma of the chosen branch is then given out
// by an energy RAM read and a result load. Results leave through a one-word output
// register, so a result waiting on the sink holds the controller only when the
// next result is to be loaded. After reset the branch table is cleared by a pass
// over all MAX_BRANCHES entries during which no request is taken; num_branches
// writes are taken always. Gamma energies are not cleared and must be written
// before they are sampled.
`default_nettype none

module weighted_branch_sampler import wbs_pkg::*; #(
	parameter int MAX_BRANCHES = MAX_BRANCHES_DEF,
	parameter int MAX_GAMMAS   = MAX_GAMMAS_DEF,
	parameter int RANDOM_BITS  = RANDOM_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	wbs_cfg_if.sink    cfg,
	wbs_req_if.sink    req,
	wbs_rsp_if.source  rsp
);

	localparam int BR_AW  = (MAX_BRANCHES > 1) ? $clog2(MAX_BRANCHES) : 1;
	localparam int E_DEP  = MAX_BRANCHES * MAX_GAMMAS;
	localparam int E_AW   = (E_DEP > 1) ? $clog2(E_DEP) : 1;
	localparam int WK_W   = $clog2(MAX_BRANCHES + 1);
	localparam int GK_W   = (MAX_GAMMAS > 1) ? $clog2(MAX_GAMMAS) : 1;
	localparam int BM_W   = GCOUNT_W + WEIGHT_W;
	localparam int RND_W  = (RANDOM_BITS < RANDOM_W) ? RANDOM_BITS : RANDOM_W;
	localparam int TGT_W  = RND_W + TOTAL_W;
	localparam int CMP_W  = TOTAL_W + RANDOM_BITS;

	// control registers
	state_t              state_q, state_d;
	logic [BR_AW-1:0]    clr_q;
	logic [NUM_BR_W-1:0] num_br_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                out_vld_q;
	logic                rd_vld_s1;

	// payload registers
	logic [BR_AW-1:0]    wbr_q;
	logic [WEIGHT_W-1:0] wwt_q;
	logic [GCOUNT_W-1:0] wcnt_q;
	logic [WK_W-1:0]     issue_q;
	logic [WK_W-1:0]     lim_q;
	logic [CMP_W-1:0]    target_q;
	logic [TOTAL_W-1:0]  sum_q;
	logic [BR_AW-1:0]    idx_s1;
	logic [BR_AW-1:0]    hit_br_q;
	logic [GCOUNT_W-1:0] n_q;
	logic [E_AW-1:0]     base_q;
	logic [GK_W-1:0]     gk_q;
	status_t             res_st_q, res_st_d;
	logic [BRANCH_W-1:0] res_br_q, res_br_d;
	logic [STATUS_W-1:0] o_st_q;
	logic [ENERGY_W-1:0] o_en_q;
	logic [BRANCH_W-1:0] o_br_q;
	logic                o_last_q;

	// RAM ports
	logic                bm_we, bm_re;
	logic [BR_AW-1:0]    bm_waddr, bm_raddr;
	logic [BM_W-1:0]     bm_wdata, bm_rdata;
	logic                em_we, em_re;
	logic [E_AW-1:0]     em_waddr, em_raddr;
	logic [ENERGY_W-1:0] em_rdata;

	// combinational helpers
	logic                acc;
	logic                bi_ok, slot_ok;
	logic [WK_W-1:0]     lim_in;
	logic [GCOUNT_W-1:0] cnt_sat;
	logic [RND_W-1:0]    rnd_eff;
	logic [TGT_W-1:0]    target_d;
	logic [TOTAL_W-1:0]  sum_next;
	logic [WEIGHT_W-1:0] rd_wt;
	logic [GCOUNT_W-1:0] rd_cnt;
	logic                walk_hit, walk_end;
	logic                issue;
	logic                gk_last;
	logic                out_free, out_load;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;

	// request decode
	assign bi_ok   = 32'(req.branch_index) < MAX_BRANCHES;
	assign slot_ok = 32'(req.gamma_slot) < MAX_GAMMAS;
	assign lim_in  = (32'(num_br_q) > MAX_BRANCHES) ? WK_W'(MAX_BRANCHES) : WK_W'(num_br_q);
	assign cnt_sat = (32'(req.gamma_count) > MAX_GAMMAS) ? GCOUNT_W'(MAX_GAMMAS)
		: req.gamma_count;
	assign rnd_eff  = req.random_fraction[RND_W-1:0];
	assign target_d = TGT_W'(rnd_eff) * TGT_W'(total_q);

	// walk compare: (sum << RANDOM_BITS) >= random * total
	assign rd_wt    = bm_rdata[WEIGHT_W-1:0];
	assign rd_cnt   = bm_rdata[BM_W-1:WEIGHT_W];
	assign sum_next = sum_q + TOTAL_W'(rd_wt);
	assign walk_hit = (CMP_W'(sum_next) << RANDOM_BITS) >= target_q;
	assign walk_end = (WK_W'(idx_s1) == lim_q - WK_W'(1));

	assign gk_last  = (32'(gk_q) + 32'd1) == 32'(n_q);
	assign out_free = !out_vld_q || rsp.ready;

	// energy write address from the request word
	assign em_waddr = E_AW'(32'(req.branch_index) * MAX_GAMMAS + 32'(req.gamma_slot));

	// next state and RAM controls
	always_comb begin
		state_d  = state_q;
		bm_we    = 1'b0;
		bm_waddr = clr_q;
		bm_wdata = '0;
		bm_re    = 1'b0;
		bm_raddr = BR_AW'(req.branch_index);
		em_we    = 1'b0;
		em_re    = 1'b0;
		em_raddr = base_q + E_AW'(gk_q);
		issue    = 1'b0;
		out_load = 1'b0;
		res_st_d = res_st_q;
		res_br_d = res_br_q;
		unique case (state_q)
			S_CLEAR: begin
				bm_we = 1'b1;
				if (clr_q == BR_AW'(MAX_BRANCHES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					res_st_d = ST_WRITE;
					res_br_d = '0;
					case (req.req_type)
						REQ_BRANCH: begin
							if (bi_ok) begin
								bm_re   = 1'b1;
								state_d = S_WUPD;
							end else begin
								state_d = S_RESULT;
							end
						end
						REQ_ENERGY: begin
							em_we   = bi_ok && slot_ok;
							state_d = S_RESULT;
						end
						REQ_SAMPLE: begin
							if (lim_in == '0 || total_q == '0) begin
								res_st_d = ST_NODATA;
								state_d  = S_RESULT;
							end else begin
								state_d = S_WALK;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_WUPD: begin
				bm_we    = 1'b1;
				bm_waddr = wbr_q;
				bm_wdata = {wcnt_q, wwt_q};
				state_d  = S_RESULT;
			end
			S_WALK: begin
				if (rd_vld_s1 && walk_hit) begin
					if (rd_cnt == '0) begin
						res_st_d = ST_EMPTY;
						res_br_d = BRANCH_W'(idx_s1);
						state_d  = S_RESULT;
					end else begin
						state_d = S_ERD;
					end
				end else if (rd_vld_s1 && walk_end) begin
					res_st_d = ST_NOTFOUND;
					res_br_d = '0;
					state_d  = S_RESULT;
				end else if (issue_q < lim_q) begin
					bm_re    = 1'b1;
					bm_raddr = issue_q[BR_AW-1:0];
					issue    = 1'b1;
				end
			end
			S_ERD: begin
				em_re   = 1'b1;
				state_d = S_EOUT;
			end
			S_EOUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = gk_last ? S_IDLE : S_ERD;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state, register, weight total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			num_br_q  <= '0;
			total_q   <= '0;
			out_vld_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + BR_AW'(1);
			end
			if (cfg.valid) begin
				num_br_q <= cfg.num_branches;
			end
			if (state_q == S_WUPD) begin
				total_q <= total_q - TOTAL_W'(rd_wt) + TOTAL_W'(wwt_q);
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		// latch request word
		if (acc) begin
			wbr_q    <= BR_AW'(req.branch_index);
			wwt_q    <= req.weight;
			wcnt_q   <= cnt_sat;
			issue_q  <= '0;
			sum_q    <= '0;
			lim_q    <= lim_in;
			target_q <= CMP_W'(target_d);
		end
		// walk bookkeeping
		if (issue) begin
			issue_q <= issue_q + WK_W'(1);
			idx_s1  <= issue_q[BR_AW-1:0];
		end
		if (state_q == S_WALK && rd_vld_s1) begin
			sum_q    <= sum_next;
			hit_br_q <= idx_s1;
			n_q      <= rd_cnt;
			base_q   <= E_AW'(32'(idx_s1) * MAX_GAMMAS);
			gk_q     <= '0;
		end
		if (state_q != S_RESULT) begin
			res_st_q <= res_st_d;
			res_br_q <= res_br_d;
		end
		// result word
		if (out_load) begin
			if (state_q == S_EOUT) begin
				o_st_q   <= ST_GAMMA;
				o_en_q   <= em_rdata;
				o_br_q   <= BRANCH_W'(hit_br_q);
				o_last_q <= gk_last;
				gk_q     <= gk_q + GK_W'(1);
			end else begin
				o_st_q   <= res_st_q;
				o_en_q   <= '0;
				o_br_q   <= res_br_q;
				o_last_q <= 1'b1;
			end
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.status        = o_st_q;
	assign rsp.energy_out    = o_en_q;
	assign rsp.chosen_branch = o_br_q;
	assign rsp.last          = o_last_q;

	// branch table: {gamma count, weight}
	wbs_ram #(
		.WIDTH (BM_W),
		.DEPTH (MAX_BRANCHES)
	) u_branch_ram (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.re    (bm_re),
		.raddr (bm_raddr),
		.rdata (bm_rdata)
	);

	// gamma energies, MAX_GAMMAS slots per branch
	wbs_ram #(
		.WIDTH (ENERGY_W),
		.DEPTH (E_DEP)
	) u_energy_ram (
		.clk   (clk),
		.we    (em_we),
		.waddr (em_waddr),
		.wdata (req.energy_in),
		.re    (em_re),
		.raddr (em_raddr),
		.rdata (em_rdata)
	);

endmodule

`default_nettype wire

// File: rtl/wbs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module wbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
